FILE: hw/rtl/diff_drive_odometry_assert.svh
// Assertion macros for the wheel odometry block.
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ddo assertion failed");
`define DDO_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ddo assertion failed");
`else
`define DDO_ASSERT_IMP(name, pre, post)
`define DDO_ASSERT_NXT(name, pre, post)
`endif
`endif

FILE: hw/rtl/ddo_pkg.sv
// Shared types, constants and the step program of the wheel odometry block.
package ddo_pkg;

  localparam int PC_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FEET_PER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE            = 2'd2;

  localparam logic [31:0] FEET_PER_COUNT_RESET  = 32'd1200000;
  localparam logic [31:0] INV_TRACK_WIDTH_RESET = 32'd33554432;
  localparam logic [12:0] SAMPLE_RATE_RESET     = 13'd100;

  localparam logic signed [31:0] TWO_PI_WRAP     = 32'sd1686629362;
  localparam logic signed [31:0] HEADING_RESET   = -32'sd421657341;
  localparam logic signed [33:0] PI_Q28          = 34'sd843314857;
  localparam logic signed [33:0] TWO_PI_Q28      = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q28     = 34'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [32:0] FT_TO_M_Q30     = 33'sd327276508;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_DL, OP_DR, OP_DRW, OP_SUM, OP_ABS, OP_TPH, OP_TPL,
    OP_TFIN, OP_TSGN, OP_CLD_INC, OP_CLD_HW, OP_CLD_Q, OP_CFOLD, OP_CITER,
    OP_CEND_INC, OP_CEND_HW, OP_CEND_Q, OP_CLAMP, OP_SET_XR, OP_SET_YR,
    OP_SET_XSA, OP_SET_YCA, OP_SET_YSA, OP_SET_XCA, OP_MQ_HI, OP_MQ_LO,
    OP_MQ_FIN, OP_DY, OP_POSE, OP_SET_PX, OP_SET_PY, OP_SET_CV, OP_V_HI,
    OP_V_LO, OP_V_FIN, OP_A_MUL, OP_A_FIN, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic citer_last;
  } sts_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd843314857;
      5'd1: r = 30'd497837829;
      5'd2: r = 30'd263043837;
      5'd3: r = 30'd133525159;
      5'd4: r = 30'd67021687;
      5'd5: r = 30'd33543516;
      5'd6: r = 30'd16775851;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194283;
      5'd9: r = 30'd2097149;
      5'd31: r = '0;
      default: r = 30'(32'd1 << (5'd30 - i));
    endcase
    return r;
  endfunction

  function automatic op_t prog_op(input logic [PC_W-1:0] pc);
    op_t r;
    case (pc)
      7'd0: r = OP_DL;
      7'd1: r = OP_DR;
      7'd2: r = OP_DRW;
      7'd3: r = OP_SUM;
      7'd4: r = OP_ABS;
      7'd5: r = OP_TPH;
      7'd6: r = OP_TPL;
      7'd7: r = OP_TFIN;
      7'd8: r = OP_TSGN;
      7'd9: r = OP_CLD_INC;
      7'd10, 7'd14, 7'd45: r = OP_CFOLD;
      7'd11, 7'd15, 7'd46: r = OP_CITER;
      7'd12: r = OP_CEND_INC;
      7'd13: r = OP_CLD_HW;
      7'd16: r = OP_CEND_HW;
      7'd17: r = OP_CLAMP;
      7'd18: r = OP_SET_XR;
      7'd22: r = OP_SET_YR;
      7'd26: r = OP_SET_XSA;
      7'd30: r = OP_SET_YCA;
      7'd34: r = OP_SET_YSA;
      7'd38: r = OP_SET_XCA;
      7'd19, 7'd23, 7'd27, 7'd31, 7'd35, 7'd39, 7'd49, 7'd53, 7'd57: r = OP_MQ_HI;
      7'd20, 7'd24, 7'd28, 7'd32, 7'd36, 7'd40, 7'd50, 7'd54, 7'd58: r = OP_MQ_LO;
      7'd21, 7'd25, 7'd29, 7'd33, 7'd37, 7'd41, 7'd51, 7'd55, 7'd59: r = OP_MQ_FIN;
      7'd42: r = OP_DY;
      7'd43: r = OP_POSE;
      7'd44: r = OP_CLD_Q;
      7'd47: r = OP_CEND_Q;
      7'd48: r = OP_SET_PX;
      7'd52: r = OP_SET_PY;
      7'd56: r = OP_SET_CV;
      7'd60: r = OP_V_HI;
      7'd61: r = OP_V_LO;
      7'd62: r = OP_V_FIN;
      7'd63: r = OP_A_MUL;
      7'd64: r = OP_A_FIN;
      default: r = OP_EMIT;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/ddo_if.sv
// Valid/ready channel interfaces of the wheel odometry block.
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, output left_count, output right_count, input ready);
  modport sink (input valid, input left_count, input right_count, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x_m;
  logic signed [31:0] pos_y_m;
  logic signed [31:0] heading_rad;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;
  logic signed [31:0] lin_vel;
  logic signed [31:0] ang_vel;
  modport source (output valid, output pos_x_m, output pos_y_m, output heading_rad,
                  output quat_z, output quat_w, output lin_vel, output ang_vel,
                  input ready);
  modport sink (input valid, input pos_x_m, input pos_y_m, input heading_rad,
                input quat_z, input quat_w, input lin_vel, input ang_vel,
                output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/diff_drive_odometry.sv
// Top level of the differential-drive wheel odometry block.
// Input channel in_ch transfers one sample of the left and right absolute encoder
// counts; output channel out_ch transfers one pose record per sample: position
// in metres, heading, yaw quaternion (z, w) and linear and angular velocity.
// Configuration channel cfg_ch writes feet_per_count, inv_track_width and the
// sample rate by index; it is always ready. The user must write it only while
// idle; the block itself does not enforce this. Each item is processed to
// completion before the next is accepted; the timing is set by the sequencer
// program: three passes of one iterative CORDIC unit at one step per cycle
// plus one shared 33x33 multiplier used for every product in turn.
// A finished result waits in the output register; the next sample is taken
// meanwhile and processed, and the final write of the output register holds
// until the receiver takes the previous result.
// Reset clears the previous counts and the pose, sets the heading to minus
// pi/2 and loads the register defaults; no result is pending afterwards.
`include "diff_drive_odometry_assert.svh"
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS  = 24,
  parameter int POS_FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  ddo_in_if.sink    in_ch,
  ddo_out_if.source out_ch,
  ddo_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ddo_dp #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .left_count  (in_ch.left_count),
    .right_count (in_ch.right_count),
    .cfg_write   (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .pos_x_m     (out_ch.pos_x_m),
    .pos_y_m     (out_ch.pos_y_m),
    .heading_rad (out_ch.heading_rad),
    .quat_z      (out_ch.quat_z),
    .quat_w      (out_ch.quat_w),
    .lin_vel     (out_ch.lin_vel),
    .ang_vel     (out_ch.ang_vel)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  `DDO_ASSERT_NXT(a_busy_after_transfer, in_ch.valid && in_ready, !in_ready)
  `DDO_ASSERT_IMP(a_emit_only_when_free, cmd.op == OP_EMIT, !out_valid || out_ch.ready)
  `DDO_ASSERT_NXT(a_emit_sets_valid, cmd.op == OP_EMIT, out_valid)

endmodule

FILE: hw/rtl/ddo_ctrl.sv
// Sequencer that steps the odometry datapath through its program.
module ddo_ctrl import ddo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_valid_r, out_valid_nxt;
  op_t             cur_op;

  always_comb begin
    cur_op        = prog_op(pc_r);
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          pc_nxt    = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cur_op == OP_EMIT) begin
          if (!out_valid_r || out_ready) begin
            cmd.op        = OP_EMIT;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.op = cur_op;
          if (cur_op != OP_CITER || sts.citer_last) begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/ddo_dp.sv
// Odometry datapath: shared multiplier, iterative CORDIC, pose state and result register.
module ddo_dp import ddo_pkg::*; #(
  parameter int CORDIC_STEPS  = 24,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic signed [31:0]   left_count,
  input  logic signed [31:0]   right_count,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic signed [31:0]   pos_x_m,
  output logic signed [31:0]   pos_y_m,
  output logic signed [31:0]   heading_rad,
  output logic signed [31:0]   quat_z,
  output logic signed [31:0]   quat_w,
  output logic signed [31:0]   lin_vel,
  output logic signed [31:0]   ang_vel
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam int POS_SH = 24 - POS_FRAC_BITS;
  localparam logic signed [56:0] CP_MAX = 57'sd1 <<< 40;
  localparam logic signed [56:0] CV_MAX = 57'sd1 <<< 44;

  logic [31:0]        fpc_r, itw_r;
  logic [12:0]        rate_r;
  logic signed [31:0] last_l_r, last_r_r, pose_x_r, pose_y_r, heading_r;

  logic signed [31:0] in_l_r, in_r_r, hw_r, inc_r;
  logic               sgn_r, dsgn_r, cneg_r;
  logic signed [56:0] dl_r, dr_r, ctr_r;
  logic signed [57:0] diff_r;
  logic [57:0]        dmag_r;
  logic [45:0]        tr_r;
  logic signed [65:0] prod_r, t_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [STEP_W-1:0]  cnt_r;
  logic signed [31:0] si_r, ci_r, sa_r, ca_r, qz_r, qw_r;
  logic signed [41:0] cp_r, xr_r, yr_r;
  logic signed [45:0] cv_r;
  logic signed [47:0] ma_r, mq_r, acc_r, dx_r, dy_r;
  logic signed [32:0] mb_r;
  logic signed [31:0] ox_r, oy_r, lv_r, av_r;
  logic signed [31:0] o_x_r, o_y_r, o_hd_r, o_qz_r, o_qw_r, o_lv_r, o_av_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] delta_l, delta_r, cld_src;
  logic [31:0]        mag_l, mag_r;
  logic [55:0]        pt;
  logic signed [56:0] tv;
  logic signed [57:0] sum58;
  logic [45:0]        tsum, cap, tcl;
  logic signed [33:0] a34, fold, xn, yn, atan_v, cdx, cdy;
  logic signed [48:0] px_sum, py_sum;
  logic signed [32:0] hd_sum;
  logic signed [31:0] hw_wrap;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) r = 32'sd1073741824;
    else if (v < -34'sd1073741824) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    delta_l = in_l_r - last_l_r;
    delta_r = in_r_r - last_r_r;
    mag_l   = delta_l[31] ? 32'(-delta_l) : delta_l;
    mag_r   = delta_r[31] ? 32'(-delta_r) : delta_r;
    pt      = prod_r[63:8];
    tv      = sgn_r ? -$signed({1'b0, pt}) : $signed({1'b0, pt});
    sum58   = 58'(dl_r) + 58'(dr_r);
    tsum    = 46'({t_r[19:0], 12'b0}) + 46'(prod_r[63:20]);
    cap     = dsgn_r ? 46'd2147483648 : 46'd2147483647;
    tcl     = (tr_r > cap) ? cap : tr_r;
    case (cmd.op)
      OP_CLD_HW: cld_src = hw_r;
      OP_CLD_Q:  cld_src = heading_r >>> 1;
      default:   cld_src = inc_r;
    endcase
    a34 = 34'(cld_src);
    if (cz_r > HALF_PI_Q28) fold = cz_r - PI_Q28;
    else if (cz_r < -HALF_PI_Q28) fold = cz_r + PI_Q28;
    else fold = cz_r;
    xn      = cneg_r ? -cx_r : cx_r;
    yn      = cneg_r ? -cy_r : cy_r;
    atan_v  = $signed({4'b0, atan_q30(5'(cnt_r))});
    cdx     = cy_r >>> cnt_r;
    cdy     = cx_r >>> cnt_r;
    px_sum  = 49'(pose_x_r) + 49'(dx_r >>> POS_SH);
    py_sum  = 49'(pose_y_r) + 49'(dy_r >>> POS_SH);
    hd_sum  = 33'(hw_r) + 33'(inc_r);
    if (heading_r >= TWO_PI_WRAP) hw_wrap = heading_r - TWO_PI_WRAP;
    else if (heading_r <= -TWO_PI_WRAP) hw_wrap = heading_r + TWO_PI_WRAP;
    else hw_wrap = heading_r;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DL: begin
        mul_a = $signed({1'b0, mag_l});
        mul_b = $signed({1'b0, fpc_r});
      end
      OP_DR: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = $signed({1'b0, fpc_r});
      end
      OP_TPH: begin
        mul_a = $signed({7'b0, dmag_r[57:32]});
        mul_b = $signed({1'b0, itw_r});
      end
      OP_TPL: begin
        mul_a = $signed({1'b0, dmag_r[31:0]});
        mul_b = $signed({1'b0, itw_r});
      end
      OP_MQ_HI: begin
        mul_a = 33'(ma_r >>> 16);
        mul_b = mb_r;
      end
      OP_MQ_LO: begin
        mul_a = $signed({17'b0, ma_r[15:0]});
        mul_b = mb_r;
      end
      OP_V_HI: begin
        mul_a = 33'(mq_r >>> 16);
        mul_b = $signed({20'b0, rate_r});
      end
      OP_V_LO: begin
        mul_a = $signed({17'b0, mq_r[15:0]});
        mul_b = $signed({20'b0, rate_r});
      end
      OP_A_MUL: begin
        mul_a = 33'(inc_r);
        mul_b = $signed({20'b0, rate_r});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpc_r     <= FEET_PER_COUNT_RESET;
      itw_r     <= INV_TRACK_WIDTH_RESET;
      rate_r    <= SAMPLE_RATE_RESET;
      last_l_r  <= '0;
      last_r_r  <= '0;
      pose_x_r  <= '0;
      pose_y_r  <= '0;
      heading_r <= HEADING_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FEET_PER_COUNT:  fpc_r  <= cfg_data;
          REG_INV_TRACK_WIDTH: itw_r  <= cfg_data;
          REG_RATE:            rate_r <= cfg_data[12:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_DL: last_l_r <= in_l_r;
        OP_DR: last_r_r <= in_r_r;
        OP_POSE: begin
          pose_x_r  <= sat32(66'(px_sum));
          pose_y_r  <= sat32(66'(py_sum));
          heading_r <= sat32(66'(hd_sum));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        in_l_r <= left_count;
        in_r_r <= -right_count;
      end
      OP_DL: sgn_r <= delta_l[31];
      OP_DR: begin
        dl_r  <= tv;
        sgn_r <= delta_r[31];
      end
      OP_DRW: dr_r <= tv;
      OP_SUM: begin
        ctr_r  <= sum58[57:1];
        diff_r <= 58'(dr_r) - 58'(dl_r);
        hw_r   <= hw_wrap;
      end
      OP_ABS: begin
        dmag_r <= diff_r[57] ? 58'(-diff_r) : diff_r;
        dsgn_r <= diff_r[57];
      end
      OP_TPL: t_r <= prod_r;
      OP_TFIN: tr_r <= (t_r[65:20] == '0) ? tsum : '1;
      OP_TSGN: inc_r <= dsgn_r ? 32'(-tcl[31:0]) : tcl[31:0];
      OP_CLD_INC, OP_CLD_HW, OP_CLD_Q: begin
        if (a34 > PI_Q28) cz_r <= a34 - TWO_PI_Q28;
        else if (a34 < -PI_Q28) cz_r <= a34 + TWO_PI_Q28;
        else cz_r <= a34;
      end
      OP_CFOLD: begin
        cneg_r <= (cz_r > HALF_PI_Q28) || (cz_r < -HALF_PI_Q28);
        cz_r   <= fold <<< 2;
        cx_r   <= CORDIC_GAIN_Q30;
        cy_r   <= '0;
        cnt_r  <= '0;
      end
      OP_CITER: begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - cdx;
          cy_r <= cy_r + cdy;
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + cdx;
          cy_r <= cy_r - cdy;
          cz_r <= cz_r + atan_v;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      OP_CEND_INC: begin
        si_r <= clamp_q30(yn);
        ci_r <= clamp_q30(xn);
      end
      OP_CEND_HW: begin
        sa_r <= clamp_q30(yn);
        ca_r <= clamp_q30(xn);
      end
      OP_CEND_Q: begin
        qz_r <= clamp_q30(yn);
        qw_r <= clamp_q30(xn);
      end
      OP_CLAMP: begin
        if (ctr_r > CP_MAX) cp_r <= CP_MAX[41:0];
        else if (ctr_r < -CP_MAX) cp_r <= 42'(-CP_MAX);
        else cp_r <= ctr_r[41:0];
        if (ctr_r > CV_MAX) cv_r <= CV_MAX[45:0];
        else if (ctr_r < -CV_MAX) cv_r <= 46'(-CV_MAX);
        else cv_r <= ctr_r[45:0];
      end
      OP_SET_XR: begin
        ma_r <= -48'(cp_r);
        mb_r <= 33'(si_r);
      end
      OP_SET_YR: begin
        xr_r <= mq_r[41:0];
        ma_r <= 48'(cp_r);
        mb_r <= 33'(ci_r);
      end
      OP_SET_XSA: begin
        yr_r <= mq_r[41:0];
        ma_r <= 48'(xr_r);
        mb_r <= 33'(sa_r);
      end
      OP_SET_YCA: begin
        acc_r <= mq_r;
        ma_r  <= 48'(yr_r);
        mb_r  <= 33'(ca_r);
      end
      OP_SET_YSA: begin
        dx_r <= acc_r + mq_r;
        ma_r <= 48'(yr_r);
        mb_r <= 33'(sa_r);
      end
      OP_SET_XCA: begin
        acc_r <= mq_r;
        ma_r  <= 48'(xr_r);
        mb_r  <= 33'(ca_r);
      end
      OP_MQ_LO: t_r <= prod_r;
      OP_MQ_FIN: mq_r <= 48'((t_r + (prod_r >>> 16)) >>> 14);
      OP_DY: dy_r <= acc_r - mq_r;
      OP_SET_PX: begin
        ma_r <= 48'(pose_x_r);
        mb_r <= FT_TO_M_Q30;
      end
      OP_SET_PY: begin
        ox_r <= sat32(66'(mq_r));
        ma_r <= 48'(pose_y_r);
      end
      OP_SET_CV: begin
        oy_r <= sat32(66'(mq_r));
        ma_r <= 48'(cv_r);
      end
      OP_V_LO: t_r <= prod_r;
      OP_V_FIN: lv_r <= sat32((t_r <<< 8) + (prod_r >>> 8));
      OP_A_FIN: av_r <= sat32(prod_r >>> 12);
      OP_EMIT: begin
        o_x_r  <= ox_r;
        o_y_r  <= oy_r;
        o_hd_r <= heading_r;
        o_qz_r <= qz_r;
        o_qw_r <= qw_r;
        o_lv_r <= lv_r;
        o_av_r <= av_r;
      end
      default: ;
    endcase
  end

  assign sts.citer_last = (cnt_r == STEP_LAST);

  assign pos_x_m     = o_x_r;
  assign pos_y_m     = o_y_r;
  assign heading_rad = o_hd_r;
  assign quat_z      = o_qz_r;
  assign quat_w      = o_qw_r;
  assign lin_vel     = o_lv_r;
  assign ang_vel     = o_av_r;

endmodule
